@@ rtl/hpt_pkg.sv @@
// Shared types and constants for the handle packed table.
`default_nettype none

package hpt_pkg;

    localparam int SLOTS    = 256;
    localparam int IDX_W    = $clog2(SLOTS);
    localparam int CNT_W    = IDX_W + 1;
    localparam int HANDLE_W = 16;
    localparam int DENSE_W  = 8;

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_REMOVE   = 2'd1,
        OP_CONTAINS = 2'd2,
        OP_LOOKUP   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_ABSENT = 2'd2
    } t_status;

    typedef struct packed {
        t_op                 operation;
        logic [HANDLE_W-1:0] handle;
    } t_in_item;

    typedef struct packed {
        t_status             status;
        logic                found;
        logic [HANDLE_W-1:0] new_handle;
        logic [DENSE_W-1:0]  dense_index;
        logic [DENSE_W-1:0]  moved_from;
        logic [DENSE_W-1:0]  moved_to;
        logic [8:0]          live_count;
    } t_out_item;

    // Free queue controls from the execute stage.
    typedef struct packed {
        logic push;
        logic pop;
    } t_fq_ctl;

endpackage

`default_nettype wire

@@ rtl/hpt_ram.sv @@
// Generic single-write, single-read RAM with registered read data (old data on collision).
`default_nettype none

module hpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/hpt_free_queue.sv @@
// Free handle queue: circular buffer that starts out holding every handle in order.
`default_nettype none

module hpt_free_queue
    import hpt_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_fq_ctl          i_ctl,
    input  wire logic [IDX_W-1:0] i_push_handle,
    output logic      [IDX_W-1:0] o_head
);

    logic [IDX_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [IDX_W-1:0] r_wr_ptr;
    logic             r_wrapped;
    logic [IDX_W-1:0] r_raddr;
    logic             r_fwd_en;
    logic [IDX_W-1:0] r_fwd_addr;
    logic [IDX_W-1:0] r_fwd_data;
    logic [IDX_W-1:0] ram_q;
    logic             written;

    // Head read is issued for the pointer after this cycle's pop.
    assign n_rd_ptr = r_rd_ptr + IDX_W'(i_ctl.pop);

    hpt_ram #(
        .WIDTH (IDX_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.push),
        .i_waddr (r_wr_ptr),
        .i_wdata (i_push_handle),
        .i_raddr (n_rd_ptr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr  <= '0;
            r_wr_ptr  <= '0;
            r_wrapped <= 1'b0;
            r_fwd_en  <= 1'b0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_fwd_en <= i_ctl.push;
            if (i_ctl.push) begin
                r_wr_ptr <= r_wr_ptr + IDX_W'(1);
                if (r_wr_ptr == IDX_W'(SLOTS - 1)) begin
                    r_wrapped <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_raddr    <= n_rd_ptr;
        r_fwd_addr <= r_wr_ptr;
        r_fwd_data <= i_push_handle;
    end

    // Entries not yet written in the first lap still hold their own index.
    assign written = r_wrapped || (r_raddr < r_wr_ptr);

    always_comb begin
        priority if (r_fwd_en && (r_fwd_addr == r_raddr)) begin
            o_head = r_fwd_data;
        end else if (written) begin
            o_head = ram_q;
        end else begin
            o_head = r_raddr;
        end
    end

endmodule

`default_nettype wire

@@ rtl/handle_packed_table_core.sv @@
// Handle table over a dense packed array: add, remove with swap-last, contains and lookup.
// An accepted item is held in the input register, then the execute stage writes its result
// to the output register; throughput is one item per cycle while the output is not stalled,
// set by the single execute stage that consumes the registered reads of the handle, dense
// and free-queue RAMs (writes of the item just ahead are forwarded). Handle liveness sits in
// one flip-flop per slot, so the block is ready right after reset with no clearing pass. An
// item waits in the input register only while the output register is full and stalled.
`default_nettype none

module handle_packed_table_core
    import hpt_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_item
);

    t_in_item         r_in;
    logic             r_in_valid;
    t_out_item        r_out;
    logic             r_out_valid;
    logic [CNT_W-1:0] r_count, n_count;
    logic [SLOTS-1:0] r_live, n_live;

    logic             in_accept;
    logic             exec_fire;
    t_out_item        res;
    t_fq_ctl          fq_ctl;
    logic [IDX_W-1:0] fq_head;

    // handle -> dense RAM and its forwarding path
    logic             h2d_we;
    logic [IDX_W-1:0] h2d_waddr, h2d_wdata, h2d_raddr, h2d_q;
    logic [IDX_W-1:0] r_h2d_raddr;
    logic             r_h2d_fwd_en;
    logic [IDX_W-1:0] r_h2d_fwd_addr, r_h2d_fwd_data;

    // dense -> handle RAM and its forwarding path
    logic             d2h_we;
    logic [IDX_W-1:0] d2h_waddr, d2h_wdata, d2h_raddr, d2h_q;
    logic [IDX_W-1:0] r_d2h_raddr;
    logic             r_d2h_fwd_en;
    logic [IDX_W-1:0] r_d2h_fwd_addr, r_d2h_fwd_data;

    logic [HANDLE_W-1:0] h;
    logic [IDX_W-1:0]    hidx;
    logic                in_range;
    logic                live;
    logic                full;
    logic                add_ok;
    logic                rem_ok;
    logic [IDX_W-1:0]    cur_dense;
    logic [IDX_W-1:0]    last_dense;
    logic [IDX_W-1:0]    moved_handle;
    logic [IDX_W-1:0]    cnt_idx;
    logic [IDX_W-1:0]    n_handle;

    assign exec_fire  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = !i_rst_n || (r_in_valid && !exec_fire);
    assign in_accept  = i_in_valid && !o_in_stall;

    assign h          = r_in.handle;
    assign hidx       = h[IDX_W-1:0];
    assign in_range   = ({1'b0, h} < (HANDLE_W + 1)'(SLOTS));
    assign live       = in_range && r_live[hidx];
    assign full       = (r_count == CNT_W'(SLOTS));
    assign cnt_idx    = r_count[IDX_W-1:0];
    assign last_dense = IDX_W'(r_count - CNT_W'(1));

    assign cur_dense = (r_h2d_fwd_en && (r_h2d_fwd_addr == r_h2d_raddr))
                     ? r_h2d_fwd_data : h2d_q;
    assign moved_handle = (r_d2h_fwd_en && (r_d2h_fwd_addr == r_d2h_raddr))
                        ? r_d2h_fwd_data : d2h_q;

    assign add_ok = (r_in.operation == OP_ADD) && !full;
    assign rem_ok = (r_in.operation == OP_REMOVE) && live;

    always_comb begin
        res          = '0;
        res.status   = ST_OK;
        n_count      = r_count;
        n_live       = r_live;
        fq_ctl       = '0;
        h2d_we       = 1'b0;
        h2d_waddr    = fq_head;
        h2d_wdata    = cnt_idx;
        d2h_we       = 1'b0;
        d2h_waddr    = cnt_idx;
        d2h_wdata    = fq_head;

        unique case (r_in.operation)
            OP_ADD: begin
                if (full) begin
                    res.status = ST_FULL;
                end else begin
                    res.found       = 1'b1;
                    res.new_handle  = HANDLE_W'(fq_head);
                    res.dense_index = DENSE_W'(cnt_idx);
                    n_count         = r_count + CNT_W'(1);
                    n_live[fq_head] = 1'b1;
                    h2d_we          = 1'b1;
                    d2h_we          = 1'b1;
                    fq_ctl.pop      = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (!live) begin
                    res.status = ST_ABSENT;
                end else begin
                    // last entry fills the hole; when it is the removed one the
                    // writes land on dead entries
                    res.moved_from = DENSE_W'(last_dense);
                    res.moved_to   = DENSE_W'(cur_dense);
                    n_count        = r_count - CNT_W'(1);
                    n_live[hidx]   = 1'b0;
                    h2d_we         = 1'b1;
                    h2d_waddr      = moved_handle;
                    h2d_wdata      = cur_dense;
                    d2h_we         = 1'b1;
                    d2h_waddr      = cur_dense;
                    d2h_wdata      = moved_handle;
                    fq_ctl.push    = 1'b1;
                end
            end
            OP_CONTAINS, OP_LOOKUP: begin
                if (!live) begin
                    res.status = ST_ABSENT;
                end else begin
                    res.found       = 1'b1;
                    res.dense_index = DENSE_W'(cur_dense);
                end
            end
            default: begin
                res.status = ST_ABSENT;
            end
        endcase

        res.live_count = 9'(n_count);

        if (!exec_fire) begin
            n_count = r_count;
            n_live  = r_live;
            fq_ctl  = '0;
            h2d_we  = 1'b0;
            d2h_we  = 1'b0;
        end
    end

    // Reads for the item that sits in the input register next cycle.
    assign n_handle  = in_accept ? i_in_item.handle[IDX_W-1:0] : hidx;
    assign h2d_raddr = n_handle;
    assign d2h_raddr = IDX_W'(n_count - CNT_W'(1));

    hpt_ram #(
        .WIDTH (IDX_W),
        .DEPTH (SLOTS)
    ) u_h2d_ram (
        .i_clk   (i_clk),
        .i_we    (h2d_we),
        .i_waddr (h2d_waddr),
        .i_wdata (h2d_wdata),
        .i_raddr (h2d_raddr),
        .o_rdata (h2d_q)
    );

    hpt_ram #(
        .WIDTH (IDX_W),
        .DEPTH (SLOTS)
    ) u_d2h_ram (
        .i_clk   (i_clk),
        .i_we    (d2h_we),
        .i_waddr (d2h_waddr),
        .i_wdata (d2h_wdata),
        .i_raddr (d2h_raddr),
        .o_rdata (d2h_q)
    );

    hpt_free_queue u_free_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (fq_ctl),
        .i_push_handle (hidx),
        .o_head        (fq_head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_count      <= '0;
            r_live       <= '0;
            r_h2d_fwd_en <= 1'b0;
            r_d2h_fwd_en <= 1'b0;
        end else begin
            r_in_valid   <= in_accept || (r_in_valid && !exec_fire);
            if (exec_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_count      <= n_count;
            r_live       <= n_live;
            r_h2d_fwd_en <= h2d_we;
            r_d2h_fwd_en <= d2h_we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_item;
        end
        if (exec_fire) begin
            r_out <= res;
        end
        r_h2d_raddr    <= h2d_raddr;
        r_h2d_fwd_addr <= h2d_waddr;
        r_h2d_fwd_data <= h2d_wdata;
        r_d2h_raddr    <= d2h_raddr;
        r_d2h_fwd_addr <= d2h_waddr;
        r_d2h_fwd_data <= d2h_wdata;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(SLOTS))
        else $error("live count above table size");

    a_head_not_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_fire && add_ok |-> !r_live[fq_head])
        else $error("free queue head is a live handle");

    a_remove_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_fire && rem_ok |=> r_count == CNT_W'($past(r_count) - CNT_W'(1)))
        else $error("remove did not drop the live count");

    a_dense_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status == ST_OK && r_out.found
            |-> {1'b0, r_out.dense_index} < r_out.live_count)
        else $error("reported dense index beyond live entries");

endmodule

`default_nettype wire
